### rtl/mmv_pkg.sv
// Package for the MIDI message validator: byte codes, parse modes, error codes,
// the item and result structs, and the message length lookup.
// No dependencies.
package mmv_pkg;

	localparam int unsigned MAX_SEQUENCE_BYTES = 65536;
	localparam int unsigned POS_W = 16;
	// Byte position saturates at the smaller of the sequence limit less one and 65535
	localparam logic [POS_W-1:0] POS_CAP = (MAX_SEQUENCE_BYTES - 1 > 65535) ?
		POS_W'(65535) : POS_W'(MAX_SEQUENCE_BYTES - 1);

	localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
	localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
	localparam logic [7:0] BYTE_RT_FIRST    = 8'hF8;
	localparam logic [7:0] BYTE_RSV_F4      = 8'hF4;
	localparam logic [7:0] BYTE_RSV_F5      = 8'hF5;
	localparam logic [7:0] BYTE_RSV_F9      = 8'hF9;
	localparam logic [7:0] BYTE_RSV_FD      = 8'hFD;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_MSG   = 2'd1,
		MODE_SYSEX = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ERR_NONE           = 4'd0,
		ERR_RUNNING_STATUS = 4'd1,
		ERR_STRAY_EOX      = 4'd2,
		ERR_RESERVED       = 4'd3,
		ERR_SYSEX_DISABLED = 4'd4,
		ERR_SYSEX_OPEN     = 4'd5,
		ERR_STATUS_IN_SYX  = 4'd6,
		ERR_INCOMPLETE     = 4'd7,
		ERR_UNEXPECTED     = 4'd8
	} err_t;

	// Message lengths including the status byte
	localparam logic [1:0] CHAN_LEN [7] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3};
	localparam logic [1:0] SYS_LEN  [7] = '{2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic             message_done;
		err_t             error_code;
		logic [POS_W-1:0] error_index;
		logic             sequence_end;
		logic             sequence_ok;
	} result_t;

	function automatic logic is_reserved(input logic [7:0] b);
		return (b == BYTE_RSV_F4) || (b == BYTE_RSV_F5) ||
			(b == BYTE_RSV_F9) || (b == BYTE_RSV_FD);
	endfunction

	function automatic logic is_realtime(input logic [7:0] b);
		return (b >= BYTE_RT_FIRST) && !is_reserved(b);
	endfunction

	// Length of the message started by a channel status or F1..F6
	function automatic logic [1:0] msg_len(input logic [7:0] b);
		logic [2:0] idx;
		idx = 3'(b[2:0] - 3'd1);
		if (b[7:4] == 4'hF) begin
			return (idx < 3'd7) ? SYS_LEN[idx] : 2'd0;
		end else begin
			return (b[6:4] < 3'd7) ? CHAN_LEN[b[6:4]] : 2'd0;
		end
	endfunction

endpackage

### rtl/mmv_in_stage.sv
// Input register stage of the MIDI message validator.
// Depends on mmv_pkg for the item struct.
module mmv_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic          out_free,
	output logic          valid_s1,
	output mmv_pkg::item_t item_s1
);

	logic take;

	// Hold only while a byte waits and the result slot cannot take it
	assign in_stall = valid_s1 && !out_free;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= data_byte;
			item_s1.last_byte <= last_byte;
		end
	end

endmodule

### rtl/mmv_parse.sv
// Parser state and per-byte check logic of the MIDI message validator.
// Depends on mmv_pkg for modes, error codes, structs and the length lookup.
module mmv_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  mmv_pkg::item_t  item_s1,
	input  logic            sysex_en,
	output mmv_pkg::result_t result
);

	mmv_pkg::mode_t mode_q, mode_d;
	logic [1:0] rem_q, rem_d;
	mmv_pkg::err_t err_q, err_d;
	logic [mmv_pkg::POS_W-1:0] epos_q, epos_d;
	logic [mmv_pkg::POS_W-1:0] pos_q;
	logic [7:0] b;
	logic last;
	logic rsv;
	logic rt;
	logic done;
	logic [1:0] len;

	assign b    = item_s1.data_byte;
	assign last = item_s1.last_byte;
	assign rsv  = mmv_pkg::is_reserved(b);
	assign rt   = mmv_pkg::is_realtime(b);
	assign len  = mmv_pkg::msg_len(b);

	// Next parse state for this byte
	always_comb begin
		mode_d = mode_q;
		rem_d  = rem_q;
		err_d  = err_q;
		epos_d = epos_q;
		done   = 1'b0;
		if (err_q == mmv_pkg::ERR_NONE) begin
			unique case (mode_q)
				mmv_pkg::MODE_MSG: begin
					if (rsv || (b[7] && !rt)) begin
						err_d  = mmv_pkg::ERR_UNEXPECTED;
						epos_d = pos_q;
					end else if (rt) begin
						done = 1'b1;
					end else begin
						rem_d = 2'(rem_q - 2'd1);
						if (rem_d == 2'd0) begin
							mode_d = mmv_pkg::MODE_IDLE;
							done   = 1'b1;
						end
					end
				end
				mmv_pkg::MODE_SYSEX: begin
					if (rsv) begin
						err_d  = mmv_pkg::ERR_STATUS_IN_SYX;
						epos_d = pos_q;
					end else if (rt) begin
						done = 1'b1;
					end else if (b == mmv_pkg::BYTE_SYSEX_END) begin
						mode_d = mmv_pkg::MODE_IDLE;
						done   = 1'b1;
					end else if (b[7]) begin
						err_d  = mmv_pkg::ERR_STATUS_IN_SYX;
						epos_d = pos_q;
					end
				end
				default: begin
					// Idle, and the unused mode code behaves as idle
					mode_d = mmv_pkg::MODE_IDLE;
					if (rt) begin
						done = 1'b1;
					end else if (!b[7]) begin
						err_d  = mmv_pkg::ERR_RUNNING_STATUS;
						epos_d = pos_q;
					end else if (b == mmv_pkg::BYTE_SYSEX_END) begin
						err_d  = mmv_pkg::ERR_STRAY_EOX;
						epos_d = pos_q;
					end else if (rsv) begin
						err_d  = mmv_pkg::ERR_RESERVED;
						epos_d = pos_q;
					end else if (b == mmv_pkg::BYTE_SYSEX_START) begin
						if (!sysex_en) begin
							err_d  = mmv_pkg::ERR_SYSEX_DISABLED;
							epos_d = pos_q;
						end else begin
							mode_d = mmv_pkg::MODE_SYSEX;
						end
					end else if (len <= 2'd1) begin
						done = 1'b1;
					end else begin
						rem_d  = 2'(len - 2'd1);
						mode_d = mmv_pkg::MODE_MSG;
					end
				end
			endcase
			// Open message or sysex at the end of the sequence
			if (last && (err_d == mmv_pkg::ERR_NONE)) begin
				if (mode_d == mmv_pkg::MODE_MSG) begin
					err_d  = mmv_pkg::ERR_INCOMPLETE;
					epos_d = pos_q;
				end else if (mode_d == mmv_pkg::MODE_SYSEX) begin
					err_d  = mmv_pkg::ERR_SYSEX_OPEN;
					epos_d = pos_q;
				end
			end
		end
	end

	// Result for this byte
	always_comb begin
		result.message_done = done && (err_d == mmv_pkg::ERR_NONE);
		result.error_code   = err_d;
		result.error_index  = (err_d != mmv_pkg::ERR_NONE) ? epos_d : '0;
		result.sequence_end = last;
		result.sequence_ok  = last && (err_d == mmv_pkg::ERR_NONE);
	end

	// State registers; the last byte clears everything for the next sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mmv_pkg::MODE_IDLE;
			rem_q  <= 2'd0;
			err_q  <= mmv_pkg::ERR_NONE;
			epos_q <= '0;
			pos_q  <= '0;
		end else if (step) begin
			if (last) begin
				mode_q <= mmv_pkg::MODE_IDLE;
				rem_q  <= 2'd0;
				err_q  <= mmv_pkg::ERR_NONE;
				epos_q <= '0;
				pos_q  <= '0;
			end else begin
				mode_q <= mode_d;
				rem_q  <= rem_d;
				err_q  <= err_d;
				epos_q <= epos_d;
				if (pos_q < mmv_pkg::POS_CAP) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/mmv_out_stage.sv
// Result register and output handshake of the MIDI message validator.
// Depends on mmv_pkg for the result struct.
module mmv_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mmv_pkg::result_t result,
	output logic             out_free,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             message_done,
	output logic [3:0]       error_code,
	output logic [15:0]      error_index,
	output logic             sequence_end,
	output logic             sequence_ok
);

	mmv_pkg::result_t res_q;
	logic             valid_q;

	// Slot can take a new result when empty or being drained
	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_q <= result;
		end
	end

	assign out_valid    = valid_q;
	assign message_done = res_q.message_done;
	assign error_code   = res_q.error_code;
	assign error_index  = res_q.error_index;
	assign sequence_end = res_q.sequence_end;
	assign sequence_ok  = res_q.sequence_ok;

endmodule

### rtl/midi_message_validator.sv
// MIDI message validator: checks a byte sequence one byte per request.
//
// Input channel (in_valid / in_stall): data_byte plus last_byte, which marks
// the final byte of a sequence. Output channel (out_valid / out_stall): one
// result per byte: message_done, latched error_code and error_index, and on
// the last byte sequence_end with the pass/fail verdict in sequence_ok.
// Config channel (cfg_valid / cfg_ready): sysex_enabled, always ready; write
// it only while no byte is in flight.
// An accepted byte goes into the input register, then through the check
// logic into the result register, whose contents drive the outputs.
// Throughput is one byte per cycle while out_stall is low, set by the
// mode/count update on the parser state.
// Reset clears the parser state, the sysex enable and both valid flags.
// When the receiver stalls, the result holds steady; at most one more byte
// enters the input register, then in_stall stays high until the result drains.
// Depends on mmv_pkg, mmv_in_stage, mmv_parse and mmv_out_stage.
module midi_message_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        sysex_enabled,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        message_done,
	output logic [3:0]  error_code,
	output logic [15:0] error_index,
	output logic        sequence_end,
	output logic        sequence_ok
);

	logic             sysex_en_q;
	logic             out_free;
	logic             valid_s1;
	mmv_pkg::item_t   item_s1;
	mmv_pkg::result_t result;
	logic             step;

	// Config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysex_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			sysex_en_q <= sysex_enabled;
		end
	end

	assign step = valid_s1 && out_free;

	mmv_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_free  (out_free),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	mmv_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item_s1  (item_s1),
		.sysex_en (sysex_en_q),
		.result   (result)
	);

	mmv_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.result       (result),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.message_done (message_done),
		.error_code   (error_code),
		.error_index  (error_index),
		.sequence_end (sequence_end),
		.sequence_ok  (sequence_ok)
	);

endmodule

### rtl/mmv_checker.sv
// Port-level checks for the MIDI message validator, bound to the top level.
// Depends on midi_message_validator port names and mmv_pkg error codes.
module mmv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        message_done,
	input logic [3:0]  error_code,
	input logic [15:0] error_index,
	input logic        sequence_end,
	input logic        sequence_ok
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(error_code) &&
		$stable(error_index) && $stable(sequence_ok) && $stable(message_done))
		else $error("result changed while stalled");

	// A pass verdict only on the last byte and with no error
	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_ok |-> sequence_end && (error_code == mmv_pkg::ERR_NONE))
		else $error("sequence_ok without clean end");

	// No error position without an error
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == mmv_pkg::ERR_NONE) |-> (error_index == 16'd0))
		else $error("error_index set with no error");

	// Nothing completes once an error is latched
	a_err_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != mmv_pkg::ERR_NONE) |-> !message_done && !sequence_ok)
		else $error("message_done with error latched");

endmodule

bind midi_message_validator mmv_checker u_mmv_checker (.*);
